### hdl/mns_pkg.sv
// shared types and constants for the markov note sampler
// no dependencies; imported by every module of the block except the generic ram

package mns_pkg;

   // table geometry, fixed by the 4-bit note fields
   localparam int NOTES     = 16;
   localparam int NOTE_W    = 4;
   localparam int WT_DEPTH  = NOTES * NOTES;
   localparam int WT_ADDR_W = $clog2(WT_DEPTH);

   // strings cycle through 0 .. STRINGS-1
   localparam int STRINGS   = 6;
   localparam int STR_W     = 4;

   // field and datapath widths
   localparam int CMD_W     = 2;
   localparam int RND_W     = 16;
   localparam int WEIGHT_W  = 16;
   localparam int ROW_SUM_W = 20;
   localparam int PROD_W    = RND_W + ROW_SUM_W;
   localparam int DELTA_W   = 4;

   // default sequence length
   localparam int MAX_LENGTH_DEF = 64;

   // weights in tenths
   localparam logic [WEIGHT_W-1:0]  PRIOR_WEIGHT = WEIGHT_W'(1);
   localparam logic [WEIGHT_W-1:0]  SEED_WEIGHT  = WEIGHT_W'(10);
   localparam logic [WEIGHT_W-1:0]  WEIGHT_MAX   = {WEIGHT_W{1'b1}};
   localparam logic [ROW_SUM_W-1:0] ROW_SUM_INIT = ROW_SUM_W'(NOTES);

   localparam logic [NOTE_W-1:0] NOTE_LAST  = NOTE_W'(NOTES - 1);
   localparam logic [STR_W-1:0]  STR_LAST   = STR_W'(STRINGS - 1);
   localparam logic [STR_W-1:0]  STR_COUNT  = STR_W'(STRINGS);

   // command codes
   localparam logic [CMD_W-1:0] CMD_SEED  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_BEGIN = 2'd1;
   localparam logic [CMD_W-1:0] CMD_STEP  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BEGIN,
      ST_SEED_RD,
      ST_SEED_WR,
      ST_MUL,
      ST_WALK,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [NOTE_W-1:0] src_note;
      logic [NOTE_W-1:0] to_note;
      logic [STR_W-1:0]  string_start;
      logic [RND_W-1:0]  random_value;
   } req_payload_type;

   typedef struct packed {
      logic [NOTE_W-1:0] note;
      logic [STR_W-1:0]  string_num;
      logic              produced;
      logic              last;
   } rsp_payload_type;

   // weight store access
   typedef struct packed {
      logic                 en;
      logic [WT_ADDR_W-1:0] addr;
   } wt_rd_req_type;

   typedef struct packed {
      logic                 en;
      logic [WT_ADDR_W-1:0] addr;
      logic [WEIGHT_W-1:0]  data;
   } wt_wr_req_type;

endpackage

### hdl/mns_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies

module mns_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/mns_weight_store.sv
// transition weight store: ram plus one valid bit per entry
// depends on mns_pkg and mns_ram; unwritten entries read as the prior weight

module mns_weight_store (
   input  logic                        clock,
   input  logic                        reset,
   input  mns_pkg::wt_rd_req_type      rd_req,
   input  mns_pkg::wt_wr_req_type      wr_req,
   output logic [mns_pkg::WEIGHT_W-1:0] rd_weight
);

   import mns_pkg::*;

   logic                vld_ff [WT_DEPTH];
   logic                rd_vld_ff;
   logic [WEIGHT_W-1:0] ram_q;

   mns_ram #(
      .WIDTH (WEIGHT_W),
      .DEPTH (WT_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_req.en),
      .wr_addr (wr_req.addr),
      .wr_data (wr_req.data),
      .rd_en   (rd_req.en),
      .rd_addr (rd_req.addr),
      .rd_data (ram_q)
   );

   // valid bits, cleared together on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WT_DEPTH; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (wr_req.en) begin
         vld_ff[wr_req.addr] <= 1'b1;
      end
   end

   // valid bit follows the read data through the same register stage
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else if (rd_req.en) begin
         rd_vld_ff <= vld_ff[rd_req.addr];
      end
   end

   assign rd_weight = rd_vld_ff ? ram_q : PRIOR_WEIGHT;

endmodule

### hdl/markov_note_sampler_top.sv
// markov note sampler: learned transition weights, weighted draw of the next note
// order: a step does the multiply, the row walk and then the emit; a full sequence goes straight to emit
// throughput: one item at a time; seed reads then writes, begin does one subtract a cycle,
// step multiplies, then walks the row with one weight read a cycle; a stalled
// result holds the next step in its emit state
// reset: synchronous, all weights read as 1 and row sums as 16 right after reset

module markov_note_sampler_top #(
   parameter int MAX_LENGTH = mns_pkg::MAX_LENGTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  mns_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output mns_pkg::rsp_payload_type rsp_data
);

   import mns_pkg::*;

   localparam int LEN_W = $clog2(MAX_LENGTH + 1);
   localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(MAX_LENGTH);
   localparam logic [LEN_W-1:0] LEN_LAST = LEN_W'(MAX_LENGTH - 1);

   state_type            state_ff, state_in;

   // captured transfer fields
   logic [NOTE_W-1:0]    from_ff, from_in;
   logic [NOTE_W-1:0]    to_ff, to_in;
   logic [RND_W-1:0]     rnd_ff, rnd_in;

   // sequence state
   logic [NOTE_W-1:0]    cur_note_ff, cur_note_in;
   logic [LEN_W-1:0]     seq_len_ff, seq_len_in;
   logic [STR_W-1:0]     str_ctr_ff, str_ctr_in;
   logic [ROW_SUM_W-1:0] row_sum_ff [NOTES];

   // draw datapath
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [ROW_SUM_W-1:0] acc_ff, acc_in;
   logic [NOTE_W-1:0]    walk_ff, walk_in;
   logic [NOTE_W-1:0]    pick_ff, pick_in;
   logic                 full_ff, full_in;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_payload_type      rsp_data_ff, rsp_data_in;

   // control
   wt_rd_req_type        wt_rd;
   wt_wr_req_type        wt_wr;
   logic [WEIGHT_W-1:0]  weight;
   logic                 accept;
   logic                 emit_go;
   logic                 seq_full;
   logic                 walk_hit;
   logic [ROW_SUM_W-1:0] acc_sum;
   logic [ROW_SUM_W-1:0] threshold;
   logic [NOTE_W-1:0]    rs_addr;
   logic [ROW_SUM_W-1:0] rs_rd;
   logic                 rs_wr_en;
   logic [ROW_SUM_W-1:0] rs_wr_data;
   logic [WEIGHT_W:0]    seed_sum;
   logic [WEIGHT_W-1:0]  seed_weight;
   logic [DELTA_W-1:0]   seed_delta;

   mns_weight_store u_weight_store (
      .clock     (clock),
      .reset     (reset),
      .rd_req    (wt_rd),
      .wr_req    (wt_wr),
      .rd_weight (weight)
   );

   // shared status terms
   assign accept    = req_valid && req_ready;
   assign seq_full  = (seq_len_ff >= LEN_MAX);
   assign threshold = prod_ff[PROD_W-1:RND_W];
   assign acc_sum   = acc_ff + ROW_SUM_W'(weight);
   assign walk_hit  = (acc_sum > threshold) || (walk_ff == NOTE_LAST);

   // saturating seed add
   assign seed_sum    = {1'b0, weight} + {1'b0, SEED_WEIGHT};
   assign seed_weight = seed_sum[WEIGHT_W] ? WEIGHT_MAX : seed_sum[WEIGHT_W-1:0];
   assign seed_delta  = DELTA_W'(seed_weight - weight);

   // row sum store: one read address, one write
   assign rs_addr    = (state_ff == ST_SEED_WR) ? from_ff : cur_note_ff;
   assign rs_rd      = row_sum_ff[rs_addr];
   assign rs_wr_en   = (state_ff == ST_SEED_WR);
   assign rs_wr_data = rs_rd + ROW_SUM_W'(seed_delta);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_data.command)
                  CMD_SEED:  state_in = ST_SEED_RD;
                  CMD_BEGIN: state_in = ST_BEGIN;
                  CMD_STEP:  state_in = seq_full ? ST_EMIT : ST_MUL;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_BEGIN: begin
            if (str_ctr_ff <= STR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_SEED_RD: state_in = ST_SEED_WR;
         ST_SEED_WR: state_in = ST_IDLE;
         ST_MUL:     state_in = ST_WALK;
         ST_WALK: begin
            if (walk_hit) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (emit_go) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_ready = 1'b0;
      emit_go   = 1'b0;
      wt_rd     = '0;
      wt_wr     = '0;
      case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_SEED_RD: begin
            wt_rd.en   = 1'b1;
            wt_rd.addr = {from_ff, to_ff};
         end
         ST_SEED_WR: begin
            wt_wr.en   = 1'b1;
            wt_wr.addr = {from_ff, to_ff};
            wt_wr.data = seed_weight;
         end
         ST_MUL: begin
            wt_rd.en   = 1'b1;
            wt_rd.addr = {cur_note_ff, NOTE_W'(0)};
         end
         ST_WALK: begin
            wt_rd.en   = !walk_hit;
            wt_rd.addr = {cur_note_ff, walk_ff + NOTE_W'(1)};
         end
         ST_EMIT: emit_go = !rsp_valid_ff || rsp_ready;
         default: req_ready = 1'b0;
      endcase
   end

   // datapath next values
   always_comb begin
      from_in      = from_ff;
      to_in        = to_ff;
      rnd_in       = rnd_ff;
      cur_note_in  = cur_note_ff;
      seq_len_in   = seq_len_ff;
      str_ctr_in   = str_ctr_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      walk_in      = walk_ff;
      pick_in      = pick_ff;
      full_in      = full_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      // capture the transfer
      if (accept) begin
         from_in = req_data.src_note;
         to_in   = req_data.to_note;
         rnd_in  = req_data.random_value;
         full_in = seq_full;
         if (req_data.command == CMD_BEGIN) begin
            seq_len_in  = '0;
            str_ctr_in  = req_data.string_start;
            cur_note_in = req_data.random_value[NOTE_W-1:0];
         end
      end

      // reduce the starting string one subtract at a time
      if (state_ff == ST_BEGIN && str_ctr_ff > STR_LAST) begin
         str_ctr_in = str_ctr_ff - STR_COUNT;
      end

      // threshold product and walk start
      if (state_ff == ST_MUL) begin
         prod_in = PROD_W'(rnd_ff) * PROD_W'(rs_rd);
         acc_in  = '0;
         walk_in = '0;
      end

      // accumulate one weight a cycle until the running sum passes the threshold or the row ends
      if (state_ff == ST_WALK) begin
         acc_in = acc_sum;
         if (walk_hit) begin
            pick_in = walk_ff;
         end else begin
            walk_in = walk_ff + NOTE_W'(1);
         end
      end

      // load the result and, unless the sequence is full, advance the sequence
      if (emit_go) begin
         rsp_valid_in = 1'b1;
         if (full_ff) begin
            rsp_data_in.note       = '0;
            rsp_data_in.string_num = '0;
            rsp_data_in.produced   = 1'b0;
            rsp_data_in.last       = 1'b1;
         end else begin
            rsp_data_in.note       = pick_ff;
            rsp_data_in.string_num = str_ctr_ff;
            rsp_data_in.produced   = 1'b1;
            rsp_data_in.last       = (seq_len_ff == LEN_LAST);
            cur_note_in = pick_ff;
            seq_len_in  = seq_len_ff + LEN_W'(1);
            str_ctr_in  = (str_ctr_ff == STR_LAST) ? '0 : str_ctr_ff + STR_W'(1);
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cur_note_ff  <= '0;
         seq_len_ff   <= '0;
         str_ctr_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         full_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_note_ff  <= cur_note_in;
         seq_len_ff   <= seq_len_in;
         str_ctr_ff   <= str_ctr_in;
         rsp_valid_ff <= rsp_valid_in;
         full_ff      <= full_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      from_ff     <= from_in;
      to_ff       <= to_in;
      rnd_ff      <= rnd_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      walk_ff     <= walk_in;
      pick_ff     <= pick_in;
      rsp_data_ff <= rsp_data_in;
   end

   // row sums, all reset to the prior total
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NOTES; i++) begin
            row_sum_ff[i] <= ROW_SUM_INIT;
         end
      end else if (rs_wr_en) begin
         row_sum_ff[rs_addr] <= rs_wr_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
